[design/wtpsd_pkg.sv]
// types, constants and arithmetic helpers for the wind turbulence spectrum unit
// block-float format: 32-bit mantissa kept in [2^31, 2^32) or zero, small signed exponent
// no dependencies
package wtpsd_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORM   = 2'd2;

	localparam logic [19:0] COEF_A_RST = 20'd51200;
	localparam logic [15:0] COEF_B_RST = 16'd12800;
	localparam logic        FORM_RST   = 1'b0;

	localparam int DIV_STEPS    = 33;
	localparam int CBRT_STEPS   = 22;
	localparam int CBRT_TOP_SHF = 63;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_SAT        = 2'd1,
		STATUS_ZERO_SPEED = 2'd2
	} status_t;

	typedef struct packed {
		logic [23:0] freq_hz;
		logic [15:0] height_m;
		logic [15:0] mean_speed;
		logic [15:0] shear_speed;
	} item_t;

	typedef struct packed {
		logic [31:0] psd;
		status_t     status;
	} result_t;

	typedef logic signed [9:0] exp_t;

	typedef struct packed {
		logic [31:0] m;
		exp_t        e;
	} fp_t;

	// fraction bits of each fixed-point source
	localparam exp_t EXP_FREQ   = -10'sd16;
	localparam exp_t EXP_HEIGHT = -10'sd6;
	localparam exp_t EXP_SPEED  = -10'sd8;
	localparam exp_t EXP_SHEAR  = -10'sd12;
	localparam exp_t EXP_COEF   = -10'sd8;

	// exponent bias that is a multiple of three, keeps the mod-3 input positive
	localparam exp_t        EXP_BIAS3  = 10'sd96;
	localparam exp_t        EXP_BIAS3Q = 10'sd32;
	localparam logic [15:0] DIV3_MUL   = 16'd171;

	localparam fp_t FP_ONE  = '{m: 32'h8000_0000, e: -10'sd31};
	localparam fp_t FP_ZERO = '{m: 32'h0000_0000, e: 10'sd0};

	typedef struct packed {
		logic [31:0] r;
		logic [32:0] q;
	} div_lane_t;

	typedef struct packed {
		logic [21:0] y;
		logic [43:0] sq;
		logic [63:0] v;
	} cb_lane_t;

	function automatic fp_t fp_from_u24(input logic [23:0] v, input exp_t ex);
		fp_t        r;
		logic [4:0] idx;
		logic [4:0] sh;
		idx = '0;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) begin
				idx = 5'(i);
			end
		end
		sh = 5'd31 - idx;
		if (v == '0) begin
			r = FP_ZERO;
		end else begin
			r.m = {8'b0, v} << sh;
			r.e = ex - exp_t'({5'b0, sh});
		end
		return r;
	endfunction

	function automatic fp_t fp_mul(input fp_t a, input fp_t b);
		fp_t         r;
		logic [63:0] p;
		exp_t        es;
		p  = {32'b0, a.m} * {32'b0, b.m};
		es = a.e + b.e;
		if (p == '0) begin
			r = FP_ZERO;
		end else if (p[63]) begin
			r.m = p[63:32];
			r.e = es + 10'sd32;
		end else begin
			r.m = p[62:31];
			r.e = es + 10'sd31;
		end
		return r;
	endfunction

	function automatic fp_t fp_add(input fp_t a, input fp_t b);
		fp_t         r;
		fp_t         hi;
		fp_t         lo;
		logic [9:0]  d;
		logic [31:0] bm;
		logic [32:0] sum;
		if (a.m == '0) begin
			r = b;
		end else if (b.m == '0) begin
			r = a;
		end else begin
			if (a.e < b.e) begin
				hi = b;
				lo = a;
			end else begin
				hi = a;
				lo = b;
			end
			d   = 10'(hi.e - lo.e);
			bm  = (d >= 10'd32) ? 32'b0 : (lo.m >> d[4:0]);
			sum = {1'b0, hi.m} + {1'b0, bm};
			if (sum[32]) begin
				r.m = sum[32:1];
				r.e = hi.e + 10'sd1;
			end else begin
				r.m = sum[31:0];
				r.e = hi.e;
			end
		end
		return r;
	endfunction

	// quotient of the long division is in [2^31, 2^33) or zero
	function automatic fp_t fp_norm_q(input logic [32:0] q, input exp_t e);
		fp_t r;
		if (q == '0) begin
			r = FP_ZERO;
		end else if (q[32]) begin
			r.m = q[32:1];
			r.e = e + 10'sd1;
		end else begin
			r.m = q[31:0];
			r.e = e;
		end
		return r;
	endfunction

	// first quotient bit of (a << 32) / d
	function automatic div_lane_t div_lane_init(input logic [31:0] a, input logic [31:0] d);
		div_lane_t l;
		logic      bit_q;
		bit_q = (a >= d);
		l.r   = bit_q ? (a - d) : a;
		l.q   = {32'b0, bit_q};
		return l;
	endfunction

	function automatic div_lane_t div_lane_step(input div_lane_t l, input logic [31:0] d);
		div_lane_t   n;
		logic [32:0] t;
		logic [32:0] diff;
		logic        bit_q;
		t     = {l.r, 1'b0};
		diff  = t - {1'b0, d};
		bit_q = (t >= {1'b0, d});
		n.r   = bit_q ? diff[31:0] : t[31:0];
		n.q   = {l.q[31:0], bit_q};
		return n;
	endfunction

	// one digit of the integer cube root, y^2 kept alongside so no multiplier is needed
	function automatic cb_lane_t cb_step(input cb_lane_t l, input int s);
		cb_lane_t    n;
		logic [21:0] y2;
		logic [43:0] sq2;
		logic [47:0] bb;
		logic [63:0] vs;
		y2  = {l.y[20:0], 1'b0};
		sq2 = {l.sq[41:0], 2'b0};
		bb  = {4'b0, sq2} + {3'b0, sq2, 1'b0} + {26'b0, y2} + {25'b0, y2, 1'b0} + 48'd1;
		vs  = l.v >> s;
		if (vs >= {16'b0, bb}) begin
			n.v  = l.v - ({16'b0, bb} << s);
			n.y  = y2 | 22'd1;
			n.sq = sq2 + {21'b0, y2, 1'b0} + 44'd1;
		end else begin
			n.v  = l.v;
			n.y  = y2;
			n.sq = sq2;
		end
		return n;
	endfunction

endpackage

[design/wind_turbulence_psd_unit.sv]
// Kaimal-type wind turbulence spectrum, one frequency point per transaction.
// Throughput one item per cycle, except when the output stalls with every stage full.
// Latency is mostly set by two 33-stage long dividers (one quotient bit per stage) and a
// 22-stage cube root (one digit per stage). Stages advance when the stage ahead is empty
// or moving, so bubbles close up while the output waits. Reset clears all valid bits
// and loads the default coefficients; no clearing pass is needed.
module wind_turbulence_psd_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  wtpsd_pkg::item_t                    item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output wtpsd_pkg::result_t                  result,
	input  logic                                cfg_we,
	input  logic [wtpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wtpsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int ST_D1  = 3;
	localparam int ST_N1  = ST_D1 + wtpsd_pkg::DIV_STEPS;
	localparam int ST_N2  = ST_N1 + 1;
	localparam int ST_N3  = ST_N2 + 1;
	localparam int ST_PA  = ST_N3 + 1;
	localparam int ST_PB  = ST_PA + 1;
	localparam int ST_CB  = ST_PB + 1;
	localparam int ST_CN  = ST_CB + wtpsd_pkg::CBRT_STEPS;
	localparam int ST_PM  = ST_CN + 1;
	localparam int ST_F1  = ST_PM + 1;
	localparam int ST_F2  = ST_F1 + 1;
	localparam int ST_D2  = ST_F2 + 1;
	localparam int ST_OUT = ST_D2 + wtpsd_pkg::DIV_STEPS;
	localparam int PIPE   = ST_OUT;

	typedef struct packed {
		wtpsd_pkg::div_lane_t lx;
		wtpsd_pkg::div_lane_t lz;
		logic [31:0]          dvs;
		wtpsd_pkg::exp_t      ex;
		wtpsd_pkg::exp_t      ez;
		wtpsd_pkg::fp_t       aus2;
		logic                 uz;
	} d1_t;

	typedef struct packed {
		wtpsd_pkg::cb_lane_t l;
		wtpsd_pkg::exp_t     k;
		wtpsd_pkg::fp_t      p;
		logic                xz;
		wtpsd_pkg::fp_t      num;
		logic                uz;
	} cb_t;

	typedef struct packed {
		wtpsd_pkg::div_lane_t l;
		logic [31:0]          dvs;
		wtpsd_pkg::exp_t      e;
		logic                 uz;
	} d2_t;

	// configuration
	logic [19:0]    coef_a_q;
	logic [15:0]    coef_b_q;
	logic           form_q;
	wtpsd_pkg::fp_t coef_a_fp_q;
	wtpsd_pkg::fp_t coef_b_fp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= wtpsd_pkg::COEF_A_RST;
			coef_b_q <= wtpsd_pkg::COEF_B_RST;
			form_q   <= wtpsd_pkg::FORM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wtpsd_pkg::REG_COEF_A: coef_a_q <= cfg_data;
				wtpsd_pkg::REG_COEF_B: coef_b_q <= cfg_data[15:0];
				wtpsd_pkg::REG_FORM:   form_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		coef_a_fp_q <= wtpsd_pkg::fp_from_u24({4'b0, coef_a_q}, wtpsd_pkg::EXP_COEF);
		coef_b_fp_q <= wtpsd_pkg::fp_from_u24({8'b0, coef_b_q}, wtpsd_pkg::EXP_COEF);
	end

	// valid bits and per-stage advance
	logic [PIPE:1] vld_q;
	logic [PIPE:1] vld_in;
	logic [PIPE:1] en;

	assign vld_in = {vld_q[PIPE-1:1], item_valid};

	for (genvar i = 1; i <= PIPE; i++) begin : g_en
		// a stage may load when some stage at or after it is empty, or the output drains
		assign en[i] = result_ready | ~(&vld_q[PIPE:i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= PIPE; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	assign item_ready   = en[1];
	assign result_valid = vld_q[PIPE];

	// stage 1: inputs to block-float
	wtpsd_pkg::fp_t n_s1, z_s1, u_s1, us_s1;
	logic           uz_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s1  <= wtpsd_pkg::fp_from_u24(item.freq_hz, wtpsd_pkg::EXP_FREQ);
			z_s1  <= wtpsd_pkg::fp_from_u24({8'b0, item.height_m}, wtpsd_pkg::EXP_HEIGHT);
			u_s1  <= wtpsd_pkg::fp_from_u24({8'b0, item.mean_speed}, wtpsd_pkg::EXP_SPEED);
			us_s1 <= wtpsd_pkg::fp_from_u24({8'b0, item.shear_speed}, wtpsd_pkg::EXP_SHEAR);
			uz_s1 <= (item.mean_speed == '0);
		end
	end

	// stage 2: n*z and a*u*
	wtpsd_pkg::fp_t nz_s2, aus_s2, z_s2, u_s2, us_s2;
	logic           uz_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nz_s2  <= wtpsd_pkg::fp_mul(n_s1, z_s1);
			aus_s2 <= wtpsd_pkg::fp_mul(coef_a_fp_q, us_s1);
			z_s2   <= z_s1;
			u_s2   <= u_s1;
			us_s2  <= us_s1;
			uz_s2  <= uz_s1;
		end
	end

	// x = n*z/U and z/U, two dividers sharing the divisor
	d1_t div1_s [wtpsd_pkg::DIV_STEPS];

	for (genvar j = 0; j < wtpsd_pkg::DIV_STEPS; j++) begin : g_div1
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[ST_D1]) begin
					div1_s[0].lx   <= wtpsd_pkg::div_lane_init(nz_s2.m, u_s2.m);
					div1_s[0].lz   <= wtpsd_pkg::div_lane_init(z_s2.m, u_s2.m);
					div1_s[0].dvs  <= u_s2.m;
					div1_s[0].ex   <= nz_s2.e - u_s2.e - 10'sd32;
					div1_s[0].ez   <= z_s2.e - u_s2.e - 10'sd32;
					div1_s[0].aus2 <= wtpsd_pkg::fp_mul(aus_s2, us_s2);
					div1_s[0].uz   <= uz_s2;
				end
			end
		end else begin : g_step
			always_ff @(posedge clk) begin
				if (en[ST_D1+j]) begin
					div1_s[j].lx   <= wtpsd_pkg::div_lane_step(div1_s[j-1].lx,
						div1_s[j-1].dvs);
					div1_s[j].lz   <= wtpsd_pkg::div_lane_step(div1_s[j-1].lz,
						div1_s[j-1].dvs);
					div1_s[j].dvs  <= div1_s[j-1].dvs;
					div1_s[j].ex   <= div1_s[j-1].ex;
					div1_s[j].ez   <= div1_s[j-1].ez;
					div1_s[j].aus2 <= div1_s[j-1].aus2;
					div1_s[j].uz   <= div1_s[j-1].uz;
				end
			end
		end
	end

	// normalize quotients
	wtpsd_pkg::fp_t x_s36, zu_s36, aus2_s36;
	logic           uz_s36;

	always_ff @(posedge clk) begin
		if (en[ST_N1]) begin
			x_s36    <= wtpsd_pkg::fp_norm_q(div1_s[wtpsd_pkg::DIV_STEPS-1].lx.q,
				div1_s[wtpsd_pkg::DIV_STEPS-1].ex);
			zu_s36   <= wtpsd_pkg::fp_norm_q(div1_s[wtpsd_pkg::DIV_STEPS-1].lz.q,
				div1_s[wtpsd_pkg::DIV_STEPS-1].ez);
			aus2_s36 <= div1_s[wtpsd_pkg::DIV_STEPS-1].aus2;
			uz_s36   <= div1_s[wtpsd_pkg::DIV_STEPS-1].uz;
		end
	end

	// numerator and b*x
	wtpsd_pkg::fp_t num_s37, bx_s37, x_s37;
	logic           uz_s37;

	always_ff @(posedge clk) begin
		if (en[ST_N2]) begin
			num_s37 <= wtpsd_pkg::fp_mul(aus2_s36, zu_s36);
			bx_s37  <= wtpsd_pkg::fp_mul(coef_b_fp_q, x_s36);
			x_s37   <= x_s36;
			uz_s37  <= uz_s36;
		end
	end

	// operand of the 5/3 power
	wtpsd_pkg::fp_t p_s38, num_s38;
	logic           xz_s38, uz_s38;

	always_ff @(posedge clk) begin
		if (en[ST_N3]) begin
			p_s38   <= form_q ? x_s37 : wtpsd_pkg::fp_add(wtpsd_pkg::FP_ONE, bx_s37);
			xz_s38  <= (x_s37.m == '0);
			num_s38 <= num_s37;
			uz_s38  <= uz_s37;
		end
	end

	// exponent split into a multiple of three plus remainder
	wtpsd_pkg::exp_t pa_e8, pa_bias, pa_k;
	logic [7:0]      pa_u;
	logic [15:0]     pa_prod;
	logic [6:0]      pa_quo;
	logic [7:0]      pa_r8;
	logic [25:0]     pa_q26;

	always_comb begin
		pa_e8   = p_s38.e + 10'sd8;
		pa_bias = pa_e8 + wtpsd_pkg::EXP_BIAS3;
		pa_u    = pa_bias[7:0];
		pa_prod = {8'b0, pa_u} * wtpsd_pkg::DIV3_MUL;
		pa_quo  = pa_prod[15:9];
		pa_r8   = pa_u - ({pa_quo, 1'b0} + {1'b0, pa_quo});
		pa_k    = wtpsd_pkg::exp_t'({3'b0, pa_quo}) - wtpsd_pkg::EXP_BIAS3Q;
		pa_q26  = {2'b0, p_s38.m[31:8]} << pa_r8[1:0];
	end

	logic [25:0]     q26_s39;
	wtpsd_pkg::exp_t k_s39;
	wtpsd_pkg::fp_t  p_s39, num_s39;
	logic            xz_s39, uz_s39;

	always_ff @(posedge clk) begin
		if (en[ST_PA]) begin
			q26_s39 <= pa_q26;
			k_s39   <= pa_k;
			p_s39   <= p_s38;
			num_s39 <= num_s38;
			xz_s39  <= xz_s38;
			uz_s39  <= uz_s38;
		end
	end

	// radicand q^2 * 2^9
	cb_t         cb_s40;
	logic [51:0] pb_sq;

	assign pb_sq = {26'b0, q26_s39} * {26'b0, q26_s39};

	always_ff @(posedge clk) begin
		if (en[ST_PB]) begin
			cb_s40.l.v  <= {3'b0, pb_sq, 9'b0};
			cb_s40.l.y  <= '0;
			cb_s40.l.sq <= '0;
			cb_s40.k    <= k_s39;
			cb_s40.p    <= p_s39;
			cb_s40.xz   <= xz_s39;
			cb_s40.num  <= num_s39;
			cb_s40.uz   <= uz_s39;
		end
	end

	cb_t cbrt_s [wtpsd_pkg::CBRT_STEPS];

	for (genvar i = 0; i < wtpsd_pkg::CBRT_STEPS; i++) begin : g_cbrt
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[ST_CB]) begin
					cbrt_s[0].l   <= wtpsd_pkg::cb_step(cb_s40.l, wtpsd_pkg::CBRT_TOP_SHF);
					cbrt_s[0].k   <= cb_s40.k;
					cbrt_s[0].p   <= cb_s40.p;
					cbrt_s[0].xz  <= cb_s40.xz;
					cbrt_s[0].num <= cb_s40.num;
					cbrt_s[0].uz  <= cb_s40.uz;
				end
			end
		end else begin : g_step
			always_ff @(posedge clk) begin
				if (en[ST_CB+i]) begin
					cbrt_s[i].l   <= wtpsd_pkg::cb_step(cbrt_s[i-1].l,
						wtpsd_pkg::CBRT_TOP_SHF - 3 * i);
					cbrt_s[i].k   <= cbrt_s[i-1].k;
					cbrt_s[i].p   <= cbrt_s[i-1].p;
					cbrt_s[i].xz  <= cbrt_s[i-1].xz;
					cbrt_s[i].num <= cbrt_s[i-1].num;
					cbrt_s[i].uz  <= cbrt_s[i-1].uz;
				end
			end
		end
	end

	// cube root to block-float with exponent 2k-3
	wtpsd_pkg::fp_t cn_s63, p_s63, num_s63;
	logic           xz_s63, uz_s63;

	always_ff @(posedge clk) begin
		if (en[ST_CN]) begin
			cn_s63  <= wtpsd_pkg::fp_from_u24({2'b0, cbrt_s[wtpsd_pkg::CBRT_STEPS-1].l.y},
				cbrt_s[wtpsd_pkg::CBRT_STEPS-1].k + cbrt_s[wtpsd_pkg::CBRT_STEPS-1].k
				- 10'sd3);
			p_s63   <= cbrt_s[wtpsd_pkg::CBRT_STEPS-1].p;
			num_s63 <= cbrt_s[wtpsd_pkg::CBRT_STEPS-1].num;
			xz_s63  <= cbrt_s[wtpsd_pkg::CBRT_STEPS-1].xz;
			uz_s63  <= cbrt_s[wtpsd_pkg::CBRT_STEPS-1].uz;
		end
	end

	// p^(5/3) = p * p^(2/3)
	wtpsd_pkg::fp_t pw_s64, num_s64;
	logic           xz_s64, uz_s64;

	always_ff @(posedge clk) begin
		if (en[ST_PM]) begin
			pw_s64  <= wtpsd_pkg::fp_mul(p_s63, cn_s63);
			num_s64 <= num_s63;
			xz_s64  <= xz_s63;
			uz_s64  <= uz_s63;
		end
	end

	// vertical form: b * x^(5/3), zero when x is zero
	wtpsd_pkg::fp_t t_s65, pw_s65, num_s65;
	logic           uz_s65;

	always_ff @(posedge clk) begin
		if (en[ST_F1]) begin
			t_s65   <= xz_s64 ? wtpsd_pkg::FP_ZERO : wtpsd_pkg::fp_mul(coef_b_fp_q, pw_s64);
			pw_s65  <= pw_s64;
			num_s65 <= num_s64;
			uz_s65  <= uz_s64;
		end
	end

	wtpsd_pkg::fp_t d_s66, num_s66;
	logic           uz_s66;

	always_ff @(posedge clk) begin
		if (en[ST_F2]) begin
			d_s66   <= form_q ? wtpsd_pkg::fp_add(wtpsd_pkg::FP_ONE, t_s65) : pw_s65;
			num_s66 <= num_s65;
			uz_s66  <= uz_s65;
		end
	end

	// psd = num / D
	d2_t div2_s [wtpsd_pkg::DIV_STEPS];

	for (genvar j = 0; j < wtpsd_pkg::DIV_STEPS; j++) begin : g_div2
		if (j == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[ST_D2]) begin
					div2_s[0].l   <= wtpsd_pkg::div_lane_init(num_s66.m, d_s66.m);
					div2_s[0].dvs <= d_s66.m;
					div2_s[0].e   <= num_s66.e - d_s66.e - 10'sd32;
					div2_s[0].uz  <= uz_s66;
				end
			end
		end else begin : g_step
			always_ff @(posedge clk) begin
				if (en[ST_D2+j]) begin
					div2_s[j].l   <= wtpsd_pkg::div_lane_step(div2_s[j-1].l, div2_s[j-1].dvs);
					div2_s[j].dvs <= div2_s[j-1].dvs;
					div2_s[j].e   <= div2_s[j-1].e;
					div2_s[j].uz  <= div2_s[j-1].uz;
				end
			end
		end
	end

	// Q16.16 conversion with saturation
	wtpsd_pkg::fp_t     ot_psd;
	wtpsd_pkg::exp_t    ot_sh;
	logic [9:0]         ot_amt;
	wtpsd_pkg::result_t ot_res;

	always_comb begin
		ot_psd = wtpsd_pkg::fp_norm_q(div2_s[wtpsd_pkg::DIV_STEPS-1].l.q,
			div2_s[wtpsd_pkg::DIV_STEPS-1].e);
		ot_sh  = ot_psd.e + 10'sd16;
		ot_amt = 10'(-ot_sh);
		ot_res.status = wtpsd_pkg::STATUS_OK;
		ot_res.psd    = '0;
		if (div2_s[wtpsd_pkg::DIV_STEPS-1].uz) begin
			ot_res.status = wtpsd_pkg::STATUS_ZERO_SPEED;
		end else if (ot_psd.m == '0) begin
			ot_res.psd = '0;
		end else if (ot_sh > 10'sd0) begin
			ot_res.psd    = '1;
			ot_res.status = wtpsd_pkg::STATUS_SAT;
		end else if (ot_amt >= 10'd32) begin
			ot_res.psd = '0;
		end else begin
			ot_res.psd = ot_psd.m >> ot_amt[4:0];
		end
	end

	wtpsd_pkg::result_t res_s100;

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			res_s100 <= ot_res;
		end
	end

	assign result = res_s100;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> vld_q[1])
		else $error("accepted transaction did not enter the first stage");

	a_zero_speed_psd: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == wtpsd_pkg::STATUS_ZERO_SPEED) |-> result.psd == '0)
		else $error("zero mean speed result carries nonzero psd");

	a_sat_psd: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == wtpsd_pkg::STATUS_SAT) |-> result.psd == '1)
		else $error("saturated result is not full scale");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(res_s100)))
		else $error("stalled output stage changed");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// testbench for wind_turbulence_psd_unit: directed and random spectrum points checked
// against a block-float predictor of the Kaimal spectrum, under varying handshake idling
// depends on wtpsd_pkg and wind_turbulence_psd_unit
module testbench;

	localparam logic [wtpsd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 110;

	typedef struct {
		longint unsigned m;
		int              e;
	} bfloat_t;

	logic                                clk;
	logic                                arst_n;
	logic                                item_valid;
	logic                                item_ready;
	wtpsd_pkg::item_t                    item;
	logic                                result_valid;
	logic                                result_ready;
	wtpsd_pkg::result_t                  result;
	logic                                cfg_we;
	logic [wtpsd_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [wtpsd_pkg::CFG_DATA_W-1:0]    cfg_data;

	logic [19:0] model_coef_a;
	logic [15:0] model_coef_b;
	logic        model_form;

	wtpsd_pkg::result_t expected_psd_q[$];
	int  send_idle_pct;
	int  recv_stall_pct;
	int  errors;
	int  cycles;

	wind_turbulence_psd_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bfloat_t bf_norm(input longint unsigned v, input int ex);
		bfloat_t r;
		r.m = 0;
		r.e = 0;
		if (v != 0) begin
			while (v >= 64'h1_0000_0000) begin
				v = v >> 1;
				ex++;
			end
			while (v < 64'h8000_0000) begin
				v = v << 1;
				ex--;
			end
			r.m = v;
			r.e = ex;
		end
		return r;
	endfunction

	function automatic bfloat_t bf_mul(input bfloat_t a, input bfloat_t b);
		return bf_norm(a.m * b.m, a.e + b.e);
	endfunction

	function automatic bfloat_t bf_div(input bfloat_t a, input bfloat_t b);
		return bf_norm((a.m << 32) / b.m, a.e - b.e - 32);
	endfunction

	function automatic bfloat_t bf_add(input bfloat_t a, input bfloat_t b);
		bfloat_t t;
		int      d;
		longint unsigned bm;
		if (a.m == 0) return b;
		if (b.m == 0) return a;
		if (a.e < b.e) begin
			t = a;
			a = b;
			b = t;
		end
		d  = a.e - b.e;
		bm = (d >= 63) ? 64'd0 : (b.m >> d);
		return bf_norm(a.m + bm, a.e);
	endfunction

	function automatic longint unsigned int_cube_root(input longint unsigned v);
		longint unsigned y;
		longint unsigned b;
		y = 0;
		for (int s = 63; s >= 0; s -= 3) begin
			y = 2 * y;
			b = 3 * y * (y + 1) + 1;
			if ((v >> s) >= b) begin
				v = v - (b << s);
				y++;
			end
		end
		return y;
	endfunction

	// v^(5/3) as v * v^(2/3), exponent folded to a multiple of three
	function automatic bfloat_t bf_pow_five_thirds(input bfloat_t a);
		longint unsigned q;
		longint unsigned c;
		int ex;
		int r;
		int k;
		q  = a.m >> 8;
		ex = a.e + 8;
		r  = ((ex % 3) + 3) % 3;
		q  = q << r;
		k  = (ex - r) / 3;
		c  = int_cube_root((q * q) << 9);
		return bf_mul(a, bf_norm(c, 2 * k - 3));
	endfunction

	function automatic wtpsd_pkg::result_t kaimal_psd(input wtpsd_pkg::item_t it);
		wtpsd_pkg::result_t res;
		bfloat_t n, z, u, us, ca, cb, one, x, zu, num, d, t, s;
		int sh;
		res.psd    = '0;
		res.status = wtpsd_pkg::STATUS_OK;
		if (it.mean_speed == 0) begin
			res.status = wtpsd_pkg::STATUS_ZERO_SPEED;
			return res;
		end
		n   = bf_norm(it.freq_hz, -16);
		z   = bf_norm(it.height_m, -6);
		u   = bf_norm(it.mean_speed, -8);
		us  = bf_norm(it.shear_speed, -12);
		ca  = bf_norm(model_coef_a, -8);
		cb  = bf_norm(model_coef_b, -8);
		one = bf_norm(1, 0);
		x   = bf_div(bf_mul(n, z), u);
		zu  = bf_div(z, u);
		num = bf_mul(bf_mul(bf_mul(ca, us), us), zu);
		if (model_form == 1'b0) begin
			d = bf_pow_five_thirds(bf_add(one, bf_mul(cb, x)));
		end else begin
			t.m = 0;
			t.e = 0;
			if (x.m != 0) t = bf_mul(cb, bf_pow_five_thirds(x));
			d = bf_add(one, t);
		end
		s = bf_div(num, d);
		if (s.m != 0) begin
			sh = s.e + 16;
			if (sh > 0) begin
				res.psd    = 32'hFFFF_FFFF;
				res.status = wtpsd_pkg::STATUS_SAT;
			end else if (sh > -64) begin
				res.psd = 32'(s.m >> (-sh));
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		wtpsd_pkg::result_t exp_r;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && result_valid && result_ready) begin
			if (expected_psd_q.size() == 0) begin
				$display("%0t: unexpected result psd %h status %0d", $time, result.psd,
					result.status);
				errors++;
			end else begin
				exp_r = expected_psd_q.pop_front();
				if (result.psd !== exp_r.psd) begin
					$display("%0t: psd expected %h actual %h", $time, exp_r.psd, result.psd);
					errors++;
				end
				if (result.status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
						result.status);
					errors++;
				end
			end
		end
	end

	// valid stays high across back-to-back transactions unless an idle gap is drawn
	task automatic send_item(input wtpsd_pkg::item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		expected_psd_q.push_back(kaimal_psd(it));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_psd_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [wtpsd_pkg::CFG_IDX_W-1:0] idx,
			input logic [wtpsd_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wtpsd_pkg::REG_COEF_A: model_coef_a = val;
			wtpsd_pkg::REG_COEF_B: model_coef_b = val[15:0];
			wtpsd_pkg::REG_FORM:   model_form = val[0];
			default: ;
		endcase
	endtask

	function automatic wtpsd_pkg::item_t mk_item(input logic [23:0] f, input logic [15:0] h,
			input logic [15:0] u, input logic [15:0] s);
		wtpsd_pkg::item_t it;
		it.freq_hz     = f;
		it.height_m    = h;
		it.mean_speed  = u;
		it.shear_speed = s;
		return it;
	endfunction

	function automatic wtpsd_pkg::item_t rand_item();
		wtpsd_pkg::item_t it;
		it.freq_hz     = $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(65536 * 4));
		it.height_m    = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(64 * 200));
		it.mean_speed  = $urandom_range(19) == 0 ? 16'd0 : 16'($urandom_range(1, 65535));
		it.shear_speed = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8192));
		return it;
	endfunction

	task automatic test_directed_points();
		send_item(mk_item(24'd65536, 16'd640, 16'd0, 16'd4096));
		send_item(mk_item(24'd0, 16'd640, 16'd2560, 16'd4096));
		send_item(mk_item(24'd65536, 16'd0, 16'd2560, 16'd4096));
		send_item(mk_item(24'd65536, 16'd640, 16'd2560, 16'd0));
		send_item(mk_item(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(mk_item(24'hFFFFFF, 16'hFFFF, 16'd1, 16'hFFFF));
		send_item(mk_item(24'd1, 16'd1, 16'hFFFF, 16'd1));
		send_item(mk_item(24'd0, 16'hFFFF, 16'd1, 16'hFFFF));
		send_item(mk_item(24'd6554, 16'd3200, 16'd2560, 16'd2048));
		send_item(mk_item(24'hAAAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		send_item(mk_item(24'h555555, 16'hAAAA, 16'h5555, 16'hAAAA));
		drain();
	endtask

	task automatic test_vertical_form();
		write_reg(wtpsd_pkg::REG_FORM, 20'd1);
		send_item(mk_item(24'd0, 16'd640, 16'd2560, 16'd4096));
		send_item(mk_item(24'd65536, 16'd640, 16'd2560, 16'd4096));
		send_item(mk_item(24'hFFFFFF, 16'hFFFF, 16'd1, 16'hFFFF));
		send_item(mk_item(24'd1, 16'd1, 16'hFFFF, 16'd1));
		drain();
	endtask

	task automatic test_coef_extremes();
		write_reg(wtpsd_pkg::REG_COEF_A, 20'd0);
		write_reg(wtpsd_pkg::REG_COEF_B, 20'd0);
		send_item(mk_item(24'd65536, 16'd640, 16'd2560, 16'd4096));
		drain();
		write_reg(wtpsd_pkg::REG_COEF_A, 20'hFFFFF);
		write_reg(wtpsd_pkg::REG_COEF_B, 20'hFFFFF);
		write_reg(REG_SPARE, 20'hFFFFF);
		write_reg(wtpsd_pkg::REG_FORM, 20'hFFFFE);
		send_item(mk_item(24'd65536, 16'd640, 16'd2560, 16'd4096));
		send_item(mk_item(24'hFFFFFF, 16'hFFFF, 16'd1, 16'hFFFF));
		send_item(mk_item(24'd0, 16'd64, 16'hFFFF, 16'd1));
		drain();
	endtask

	// each phase: coefficients and form written (defaults in phase 0), then random points under one idling mix
	task automatic test_random_phases();
		int idle_tab[4]  = '{0, 48, 0, 17};
		int stall_tab[4] = '{0, 0, 48, 17};
		for (int p = 0; p < 8; p++) begin
			send_idle_pct  = idle_tab[p % 4];
			recv_stall_pct = stall_tab[p % 4];
			write_reg(wtpsd_pkg::REG_COEF_A, p == 0 ? 20'd51200 : 20'($urandom));
			write_reg(wtpsd_pkg::REG_COEF_B, p == 0 ? 20'd12800 : 20'($urandom_range(65535)));
			write_reg(wtpsd_pkg::REG_FORM, 20'(p[0]));
			repeat (115) send_item(rand_item());
			drain();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		result_ready   = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		errors         = 0;
		cycles         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		model_coef_a   = wtpsd_pkg::COEF_A_RST;
		model_coef_b   = wtpsd_pkg::COEF_B_RST;
		model_form     = wtpsd_pkg::FORM_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_points();
		test_vertical_form();
		test_coef_extremes();
		test_random_phases();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
